// File: rtl/dbec_pkg.sv
package dbec_pkg;

   // request codes
   localparam logic ACT_UPDATE   = 1'b0;
   localparam logic ACT_CLASSIFY = 1'b1;

   // register indexes
   localparam int           CSR_INDEX_W           = 2;
   localparam logic [1:0]   REG_SMOOTH_WEIGHT     = 2'd0;
   localparam logic [1:0]   REG_NEAR_LIMIT        = 2'd1;
   localparam logic [1:0]   REG_FOREGROUND_MARGIN = 2'd2;

   localparam logic [15:0]  SMOOTH_WEIGHT_RESET     = 16'd58982;
   localparam logic [15:0]  NEAR_LIMIT_RESET        = 16'd500;
   localparam logic [15:0]  FOREGROUND_MARGIN_RESET = 16'd300;

   // widths
   localparam int DEPTH_W   = 16;
   localparam int ENTRY_W   = 24;
   localparam int FRAC_W    = 8;
   localparam int WEIGHT_W  = 16;
   localparam int PROD_OLD_W = ENTRY_W + WEIGHT_W;      // 40
   localparam int PROD_DEP_W = DEPTH_W + WEIGHT_W + 1;  // 33
   localparam int SUM_W      = PROD_OLD_W + 2;          // 42

   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

   // response queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   typedef struct packed {
      logic               is_background;
      logic [DEPTH_W-1:0] background_depth;
   } rsp_type;

endpackage

// File: rtl/dbec_store.sv
module dbec_store import dbec_pkg::*; #(
   parameter int DEPTH  = 307200,
   parameter int ADDR_W = 19
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data,
   output logic               busy
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               busy_ff;
   logic               busy_in;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [ADDR_W-1:0]  clr_addr_in;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [ENTRY_W-1:0] mem_wd;

   // sweep zeros through the whole map after reset
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign mem_we = busy_ff || wr_en;
   assign mem_wa = busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wd = busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

// File: rtl/dbec_rsp_fifo.sv
module dbec_rsp_fifo import dbec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rsp_type               push_data,
   input  logic                  pop,
   output logic                  out_valid,
   output rsp_type               out_data,
   output logic [FIFO_CNT_W-1:0] count
);

   rsp_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != FIFO_CNT_W'(FIFO_DEPTH))
      else $error("response queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("response queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + FIFO_CNT_W'(1))
      else $error("response queue count slip");
`endif

endmodule

// File: rtl/depth_background_ema_classifier.sv
// Per-pixel running-average background for a depth map. An update request
// (action 0) blends depth_mm into the pixel's stored Q16.8 background with
// weight smooth_weight on the old value; a zero depth leaves it alone. A
// classify request (action 1) returns one response: background when depth is
// below near_limit or less than foreground_margin closer than the stored
// value, plus the stored value's integer millimetres. The map lives in one
// single-port-read, single-port-write synchronous RAM of MAP_WIDTH*MAP_HEIGHT
// words. One request is taken every cycle; the input stalls when a request
// hits the same map entry as an update in the stage ahead of it, whose
// write-back has not reached the RAM when it reads, and holds while eight
// classify requests have been taken whose responses have not yet been popped.
// Classify responses pass through the pipeline stages into a response queue
// that holds up to eight of them at the output. After reset a clearing pass
// zeroes all MAP_WIDTH*MAP_HEIGHT map entries (307200 by default), during
// which req_stall stays high; configuration writes are taken throughout.
module depth_background_ema_classifier import dbec_pkg::*; #(
   parameter int MAP_WIDTH  = 640,
   parameter int MAP_HEIGHT = 480
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [9:0]             req_pixel_col,
   input  logic [8:0]             req_pixel_row,
   input  logic [DEPTH_W-1:0]     req_depth_mm,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_is_background,
   output logic [DEPTH_W-1:0]     rsp_background_depth,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

   localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

   // configuration
   logic [WEIGHT_W-1:0] smooth_weight_ff;
   logic [DEPTH_W-1:0]  near_limit_ff;
   logic [DEPTH_W-1:0]  foreground_margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_weight_ff     <= SMOOTH_WEIGHT_RESET;
         near_limit_ff        <= NEAR_LIMIT_RESET;
         foreground_margin_ff <= FOREGROUND_MARGIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_SMOOTH_WEIGHT:     smooth_weight_ff     <= csr_data;
            REG_NEAR_LIMIT:        near_limit_ff        <= csr_data;
            REG_FOREGROUND_MARGIN: foreground_margin_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // stage signals
   logic                  req_accept;
   logic                  s1_hold;
   logic                  clear_busy;
   logic [ADDR_W-1:0]     addr_in;
   logic                  inr_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_action_ff;
   logic                  s1_inr_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic [DEPTH_W-1:0]    s1_depth_ff;

   logic                  s2_valid_ff;
   logic                  s2_action_ff;
   logic                  s2_inr_ff;
   logic [ADDR_W-1:0]     s2_addr_ff;
   logic [DEPTH_W-1:0]    s2_depth_ff;
   logic                  s2_write;

   logic                  s3_valid_ff;
   logic                  s3_action_ff;
   logic                  s3_write_ff;
   logic [ADDR_W-1:0]     s3_addr_ff;
   logic [PROD_OLD_W-1:0] s3_prod_old_ff, prod_old_in;
   logic [PROD_DEP_W-1:0] s3_prod_dep_ff, prod_dep_in;
   logic                  s3_bg_ff, bg_in;
   logic [DEPTH_W-1:0]    s3_bg_depth_ff;

   logic                  lw_valid_ff;
   logic [ADDR_W-1:0]     lw_addr_ff;
   logic [ENTRY_W-1:0]    lw_data_ff;

   logic [ENTRY_W-1:0]    rd_data;
   logic [ENTRY_W-1:0]    old_val;
   logic [WEIGHT_W:0]     inv_weight;
   logic [ENTRY_W:0]      near_edge;
   logic [SUM_W-1:0]      blend_sum;
   logic [SUM_W-17:0]     blend_q;
   logic [ENTRY_W-1:0]    new_val;
   logic                  mem_wr;

   logic [FIFO_CNT_W-1:0] reserved_ff, reserved_in;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic                  rsp_pop;
   logic                  rsp_push;
   rsp_type               push_data;
   rsp_type               head_data;

   // address and range check at the request port
   assign inr_in  = (32'(req_pixel_col) < 32'(MAP_WIDTH)) &&
                    (32'(req_pixel_row) < 32'(MAP_HEIGHT));
   assign addr_in = ADDR_W'(ADDR_W'(req_pixel_row) * ADDR_W'(MAP_WIDTH)) +
                    ADDR_W'(req_pixel_col);

   // an update one stage ahead on the same entry has not reached the RAM yet
   assign s2_write = s2_valid_ff && (s2_action_ff == ACT_UPDATE) && s2_inr_ff &&
                     (s2_depth_ff != '0);
   assign s1_hold  = s1_valid_ff && s2_write && (s2_addr_ff == s1_addr_ff);

   assign req_stall  = clear_busy || s1_hold ||
                       (reserved_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = s1_hold ? 1'b1 : req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff && !s1_hold;
         s3_valid_ff <= s2_valid_ff;
         if (mem_wr) begin
            lw_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_action;
         s1_inr_ff    <= inr_in;
         s1_addr_ff   <= addr_in;
         s1_depth_ff  <= req_depth_mm;
      end
      if (!s1_hold) begin
         s2_action_ff <= s1_action_ff;
         s2_inr_ff    <= s1_inr_ff;
         s2_addr_ff   <= s1_addr_ff;
         s2_depth_ff  <= s1_depth_ff;
      end
      s3_action_ff   <= s2_action_ff;
      s3_write_ff    <= s2_write;
      s3_addr_ff     <= s2_addr_ff;
      s3_prod_old_ff <= prod_old_in;
      s3_prod_dep_ff <= prod_dep_in;
      s3_bg_ff       <= bg_in;
      s3_bg_depth_ff <= old_val[ENTRY_W-1:FRAC_W];
      if (mem_wr) begin
         lw_addr_ff <= s3_addr_ff;
         lw_data_ff <= new_val;
      end
   end

   dbec_store #(
      .DEPTH  (MAP_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr),
      .wr_addr (s3_addr_ff),
      .wr_data (new_val),
      .rd_addr (s1_addr_ff),
      .rd_data (rd_data),
      .busy    (clear_busy)
   );

   // stage 2: take the write that landed on the read edge, then multiply and classify
   always_comb begin
      if (!s2_inr_ff) begin
         old_val = '0;
      end else if (lw_valid_ff && (lw_addr_ff == s2_addr_ff)) begin
         old_val = lw_data_ff;
      end else begin
         old_val = rd_data;
      end
   end

   assign inv_weight  = (WEIGHT_W + 1)'(1 << WEIGHT_W) - (WEIGHT_W + 1)'(smooth_weight_ff);
   assign prod_old_in = PROD_OLD_W'(old_val) * PROD_OLD_W'(smooth_weight_ff);
   assign prod_dep_in = PROD_DEP_W'(s2_depth_ff) * PROD_DEP_W'(inv_weight);

   assign near_edge = {(ENTRY_W - FRAC_W + 1)'(s2_depth_ff) +
                       (ENTRY_W - FRAC_W + 1)'(foreground_margin_ff), {FRAC_W{1'b0}}};
   assign bg_in     = (s2_depth_ff < near_limit_ff) ||
                      (near_edge > (ENTRY_W + 1)'(old_val));

   // stage 3: round half up, saturate, write back and push classify responses
   assign blend_sum = SUM_W'(s3_prod_old_ff) +
                      SUM_W'({s3_prod_dep_ff, {FRAC_W{1'b0}}}) + ROUND_HALF;
   assign blend_q   = blend_sum[SUM_W-1:16];
   assign new_val   = (blend_q[SUM_W-17:ENTRY_W] != '0) ? {ENTRY_W{1'b1}} :
                      blend_q[ENTRY_W-1:0];
   assign mem_wr    = s3_valid_ff && s3_write_ff;

   assign rsp_push                  = s3_valid_ff && (s3_action_ff == ACT_CLASSIFY);
   assign push_data.is_background    = s3_bg_ff;
   assign push_data.background_depth = s3_bg_depth_ff;

   dbec_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (push_data),
      .pop       (rsp_pop),
      .out_valid (rsp_valid),
      .out_data  (head_data),
      .count     (fifo_count)
   );

   assign rsp_pop              = rsp_valid && !rsp_stall;
   assign rsp_is_background    = head_data.is_background;
   assign rsp_background_depth = head_data.background_depth;

   // hold a queue slot for every classify request in flight
   assign reserved_in = reserved_ff +
                        FIFO_CNT_W'(req_accept && (req_action == ACT_CLASSIFY)) -
                        FIFO_CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
      end else begin
         reserved_ff <= reserved_in;
      end
   end

`ifndef SYNTHESIS
   a_no_raw_overlap: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && mem_wr |-> s2_addr_ff != s3_addr_ff)
      else $error("read overtook a pending write-back");
   a_reserve_covers_queue: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= reserved_ff)
      else $error("response queue holds more than was reserved");
   a_reserve_bound: assert property (@(posedge clock) disable iff (reset)
      reserved_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("reservation count beyond queue depth");
   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !s1_valid_ff && !s2_valid_ff && !s3_valid_ff)
      else $error("pipeline active during clearing pass");
`endif

endmodule
